/* rtl/core/adtd_pkg.sv */
// ----------------------------------------------------------------------------
// adtd_pkg
// Shared types, constants, saturation helpers and the microcode table of the
// accelerometer difference turn detector.
// ----------------------------------------------------------------------------
`default_nettype none

package adtd_pkg;

    localparam int WINDOW_LEN_DEF = 5;

    // wide internal arithmetic width: products, accumulator, delay updates
    localparam int ACC_W  = 50;
    localparam int PROD_W = 34;
    localparam int DLY_W  = 48;
    localparam int STEP_W = 4;

    // config register map (byte address = 4 * index)
    localparam int CFG_AW = 5;
    typedef enum logic [2:0] {
        REG_DC_OFFSET = 3'd0,
        REG_THRESHOLD = 3'd1,
        REG_COEF_B0   = 3'd2,
        REG_COEF_B1   = 3'd3,
        REG_COEF_B2   = 3'd4,
        REG_COEF_A1   = 3'd5,
        REG_COEF_A2   = 3'd6,
        REG_UNUSED    = 3'd7
    } t_reg_idx;

    localparam logic signed [31:0] DC_OFFSET_RST = 32'sd0;
    localparam logic        [30:0] THRESHOLD_RST = 31'd66;
    localparam logic signed [31:0] COEF_B0_RST   = 32'sd1014320;
    localparam logic signed [31:0] COEF_B1_RST   = 32'sd2028640;
    localparam logic signed [31:0] COEF_B2_RST   = 32'sd1014320;
    localparam logic signed [31:0] COEF_A1_RST   = -32'sd2052131000;
    localparam logic signed [31:0] COEF_A2_RST   = 32'sd982449000;

    typedef struct packed {
        logic signed [31:0] b0;
        logic signed [31:0] b1;
        logic signed [31:0] b2;
        logic signed [31:0] a1;
        logic signed [31:0] a2;
    } t_coefs;

    // control word fields
    typedef enum logic [2:0] {
        COEF_B0, COEF_B1, COEF_B2, COEF_A1, COEF_A2
    } t_coef_sel;

    typedef enum logic {
        OPND_X, OPND_Y
    } t_opnd;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_IN,         // capture input word
        DST_X,          // x = sat32(a - b - dc)
        DST_Y_FILT,     // y = sat32(prod + d1)
        DST_Y_BYPASS,   // y = x
        DST_D1,         // d1 = sat48(acc - prod)
        DST_D2,         // d2 = sat48(acc - prod)
        DST_WIN         // window update, result to output register
    } t_dst;

    typedef enum logic [1:0] {
        ACC_HOLD, ACC_PROD_D2, ACC_PROD
    } t_acc;

    typedef enum logic [2:0] {
        JMP_NEXT,       // step + 1
        JMP_WAIT_IN,    // hold until an input word is taken, then step + 1
        JMP_BR_NOLP,    // target when filter bypassed, else step + 1
        JMP_GOTO,       // target
        JMP_WAIT_OUT    // hold while the output register is full, then target
    } t_jmp;

    typedef struct packed {
        logic              mul_en;
        t_coef_sel         coef;
        t_opnd             opnd;
        t_dst              dst;
        t_acc              acc;
        t_jmp              jmp;
        logic [STEP_W-1:0] target;
    } t_ctrl;

    typedef struct packed {
        logic  fire;
        t_ctrl ctrl;
    } t_issue;

    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_DIFF   = 4'd1;
    localparam logic [STEP_W-1:0] STEP_MB0    = 4'd2;
    localparam logic [STEP_W-1:0] STEP_YF     = 4'd3;
    localparam logic [STEP_W-1:0] STEP_ACC1   = 4'd4;
    localparam logic [STEP_W-1:0] STEP_D1     = 4'd5;
    localparam logic [STEP_W-1:0] STEP_ACC2   = 4'd6;
    localparam logic [STEP_W-1:0] STEP_D2     = 4'd7;
    localparam logic [STEP_W-1:0] STEP_BYPASS = 4'd8;
    localparam logic [STEP_W-1:0] STEP_WIN    = 4'd9;

    localparam t_ctrl CTRL_NOP = '{mul_en: 1'b0, coef: COEF_B0, opnd: OPND_X,
                                   dst: DST_NONE, acc: ACC_HOLD, jmp: JMP_GOTO,
                                   target: STEP_IDLE};

    // microprogram; the multiplier result is registered in prod and read by the following step
    function automatic t_ctrl adtd_ucode(input logic [STEP_W-1:0] step);
        t_ctrl c;
        c = CTRL_NOP;
        unique case (step)
            STEP_IDLE: begin
                c.dst = DST_IN;
                c.jmp = JMP_WAIT_IN;
            end
            STEP_DIFF: begin
                c.dst = DST_X;
                c.jmp = JMP_NEXT;
            end
            STEP_MB0: begin
                c.mul_en = 1'b1; c.coef = COEF_B0; c.opnd = OPND_X;
                c.jmp = JMP_BR_NOLP; c.target = STEP_BYPASS;
            end
            STEP_YF: begin
                c.mul_en = 1'b1; c.coef = COEF_B1; c.opnd = OPND_X;
                c.dst = DST_Y_FILT; c.jmp = JMP_NEXT;
            end
            STEP_ACC1: begin
                c.mul_en = 1'b1; c.coef = COEF_A1; c.opnd = OPND_Y;
                c.acc = ACC_PROD_D2; c.jmp = JMP_NEXT;
            end
            STEP_D1: begin
                c.mul_en = 1'b1; c.coef = COEF_B2; c.opnd = OPND_X;
                c.dst = DST_D1; c.jmp = JMP_NEXT;
            end
            STEP_ACC2: begin
                c.mul_en = 1'b1; c.coef = COEF_A2; c.opnd = OPND_Y;
                c.acc = ACC_PROD; c.jmp = JMP_NEXT;
            end
            STEP_D2: begin
                c.dst = DST_D2; c.jmp = JMP_GOTO; c.target = STEP_WIN;
            end
            STEP_BYPASS: begin
                c.dst = DST_Y_BYPASS; c.jmp = JMP_NEXT;
            end
            STEP_WIN: begin
                c.dst = DST_WIN; c.jmp = JMP_WAIT_OUT; c.target = STEP_IDLE;
            end
            default: c = CTRL_NOP;
        endcase
        return c;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [ACC_W-1:0] v);
        logic hi_same;
        hi_same = (&v[ACC_W-1:31]) || !(|v[ACC_W-1:31]);
        if (hi_same) return v[31:0];
        return v[ACC_W-1] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    endfunction

    function automatic logic signed [DLY_W-1:0] sat48(input logic signed [ACC_W-1:0] v);
        logic hi_same;
        hi_same = (&v[ACC_W-1:DLY_W-1]) || !(|v[ACC_W-1:DLY_W-1]);
        if (hi_same) return v[DLY_W-1:0];
        return v[ACC_W-1] ? {1'b1, {(DLY_W-1){1'b0}}} : {1'b0, {(DLY_W-1){1'b1}}};
    endfunction

endpackage

`default_nettype wire

/* rtl/core/adtd_sequencer.sv */
// ----------------------------------------------------------------------------
// adtd_sequencer
// Step counter over the microcode table, with wait and branch handling.
// ----------------------------------------------------------------------------
`default_nettype none

module adtd_sequencer (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_in_valid,
    input  wire                  i_out_full,
    input  wire                  i_lp,
    output logic                 o_in_ready,
    output adtd_pkg::t_issue     o_issue
);
    import adtd_pkg::*;

    logic [STEP_W-1:0] r_step;
    logic [STEP_W-1:0] n_step;
    t_ctrl             w_ctrl;
    logic              w_stall;

    assign w_ctrl  = adtd_ucode(r_step);
    assign w_stall = ((w_ctrl.jmp == JMP_WAIT_IN) && !i_in_valid) ||
                     ((w_ctrl.jmp == JMP_WAIT_OUT) && i_out_full);

    assign o_in_ready   = (w_ctrl.jmp == JMP_WAIT_IN);
    assign o_issue.fire = !w_stall;
    assign o_issue.ctrl = w_ctrl;

    always_comb begin
        n_step = r_step;
        if (!w_stall) begin
            unique case (w_ctrl.jmp) inside
                JMP_NEXT, JMP_WAIT_IN:  n_step = r_step + 1'b1;
                JMP_BR_NOLP:            n_step = i_lp ? r_step + 1'b1 : w_ctrl.target;
                JMP_GOTO, JMP_WAIT_OUT: n_step = w_ctrl.target;
                default:                n_step = STEP_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/adtd_datapath.sv */
// ----------------------------------------------------------------------------
// adtd_datapath
// Difference, shared 32x32 multiplier, accumulator and biquad delay state.
// ----------------------------------------------------------------------------
`default_nettype none

module adtd_datapath (
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire adtd_pkg::t_issue      i_issue,
    input  wire signed [31:0]          i_accel_a_y,
    input  wire signed [31:0]          i_accel_b_y,
    input  wire                        i_lowpass_enable,
    input  wire signed [31:0]          i_dc_offset,
    input  wire adtd_pkg::t_coefs      i_coefs,
    output logic signed [31:0]         o_y,
    output logic                       o_lp
);
    import adtd_pkg::*;

    logic signed [31:0]       r_a;
    logic signed [31:0]       r_b;
    logic                     r_lp;
    logic signed [31:0]       r_x;
    logic signed [31:0]       r_y;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [DLY_W-1:0]  r_d1;
    logic signed [DLY_W-1:0]  r_d2;

    logic signed [31:0]       w_coef;
    logic signed [31:0]       w_opnd;
    logic signed [63:0]       w_full;
    logic signed [ACC_W-1:0]  w_diff;
    logic signed [ACC_W-1:0]  w_y_sum;
    logic signed [ACC_W-1:0]  w_acc_sub;
    t_ctrl                    w_c;

    assign w_c = i_issue.ctrl;

    always_comb begin
        case (w_c.coef)
            COEF_B0: w_coef = i_coefs.b0;
            COEF_B1: w_coef = i_coefs.b1;
            COEF_B2: w_coef = i_coefs.b2;
            COEF_A1: w_coef = i_coefs.a1;
            COEF_A2: w_coef = i_coefs.a2;
            default: w_coef = i_coefs.b0;
        endcase
    end

    assign w_opnd = (w_c.opnd == OPND_Y) ? r_y : r_x;
    assign w_full = w_coef * w_opnd;

    assign w_diff    = ACC_W'(r_a) - ACC_W'(r_b) - ACC_W'(i_dc_offset);
    assign w_y_sum   = ACC_W'(r_prod) + ACC_W'(r_d1);
    assign w_acc_sub = r_acc - ACC_W'(r_prod);

    // floor(coef * v / 2^30) is just the upper bits of the full product
    always_ff @(posedge i_clk) begin
        if (i_issue.fire && w_c.mul_en) begin
            r_prod <= w_full[63:30];
        end
        if (i_issue.fire) begin
            case (w_c.acc)
                ACC_PROD_D2: r_acc <= ACC_W'(r_prod) + ACC_W'(r_d2);
                ACC_PROD:    r_acc <= ACC_W'(r_prod);
                default:     r_acc <= r_acc;
            endcase
            unique case (w_c.dst)
                DST_IN: begin
                    r_a  <= i_accel_a_y;
                    r_b  <= i_accel_b_y;
                    r_lp <= i_lowpass_enable;
                end
                DST_X:        r_x <= sat32(w_diff);
                DST_Y_FILT:   r_y <= sat32(w_y_sum);
                DST_Y_BYPASS: r_y <= r_x;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d1 <= '0;
            r_d2 <= '0;
        end else if (i_issue.fire) begin
            if (w_c.dst == DST_D1) r_d1 <= sat48(w_acc_sub);
            if (w_c.dst == DST_D2) r_d2 <= sat48(w_acc_sub);
        end
    end

    assign o_y  = r_y;
    assign o_lp = r_lp;

endmodule

`default_nettype wire

/* rtl/core/adtd_window.sv */
// ----------------------------------------------------------------------------
// adtd_window
// Circular window with running sum and sign counts; turn decision.
// ----------------------------------------------------------------------------
`default_nettype none

module adtd_window #(
    parameter int WINDOW_LEN = adtd_pkg::WINDOW_LEN_DEF
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_wr,
    input  wire signed [31:0]  i_y,
    input  wire        [30:0]  i_threshold,
    output logic               o_turning
);
    import adtd_pkg::*;

    localparam int SLOT_W = $clog2(WINDOW_LEN);
    localparam int CNT_W  = $clog2(WINDOW_LEN + 1);
    localparam int SUM_W  = 32 + $clog2(WINDOW_LEN);

    logic signed [31:0]      r_win [WINDOW_LEN];
    logic [SLOT_W-1:0]       r_slot;
    logic signed [SUM_W-1:0] r_sum;
    logic [CNT_W-1:0]        r_pos;
    logic [CNT_W-1:0]        r_neg;

    logic signed [31:0]      w_old;
    logic signed [SUM_W-1:0] n_sum;
    logic [CNT_W-1:0]        n_pos;
    logic [CNT_W-1:0]        n_neg;
    logic [SUM_W-1:0]        w_mag;
    logic [SUM_W-1:0]        w_limit;
    logic                    w_y_pos;
    logic                    w_y_neg;
    logic                    w_old_pos;
    logic                    w_old_neg;

    assign w_old     = r_win[r_slot];
    assign w_y_pos   = !i_y[31] && (|i_y);
    assign w_y_neg   = i_y[31];
    assign w_old_pos = !w_old[31] && (|w_old);
    assign w_old_neg = w_old[31];

    // running totals replace the overwritten entry
    assign n_sum = r_sum - SUM_W'(w_old) + SUM_W'(i_y);
    assign n_pos = r_pos + CNT_W'(w_y_pos) - CNT_W'(w_old_pos);
    assign n_neg = r_neg + CNT_W'(w_y_neg) - CNT_W'(w_old_neg);

    assign w_mag   = n_sum[SUM_W-1] ? SUM_W'(-n_sum) : SUM_W'(n_sum);
    assign w_limit = SUM_W'(i_threshold) * SUM_W'(WINDOW_LEN);

    assign o_turning = (w_mag > w_limit) &&
                       ((n_pos == CNT_W'(WINDOW_LEN)) || (n_neg == CNT_W'(WINDOW_LEN)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < WINDOW_LEN; k++) begin
                r_win[k] <= '0;
            end
            r_slot <= '0;
            r_sum  <= '0;
            r_pos  <= '0;
            r_neg  <= '0;
        end else if (i_wr) begin
            r_win[r_slot] <= i_y;
            r_slot <= (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
            r_sum  <= n_sum;
            r_pos  <= n_pos;
            r_neg  <= n_neg;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/accel_difference_turn_detector_top.sv */
// An input word is taken only at the idle step, so the next word is not accepted until
// the last one has reached the output register; the five biquad products pass one at a
// time through a single shared 32x32 multiplier.
// A full output register holds the sequencer at its last step until the word is taken.
// Reset (synchronous, active low) restores config defaults and clears the biquad
// delays, the window, its running sum and the sequencer.
// ----------------------------------------------------------------------------
// accel_difference_turn_detector_top
// Microcoded turn detector: offset-corrected accelerometer difference,
// optional biquad lowpass, moving-window average threshold.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_difference_turn_detector_top #(
    parameter int WINDOW_LEN = adtd_pkg::WINDOW_LEN_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // s_axis_tdata: [31:0] accel_a_y, [63:32] accel_b_y, [64] lowpass_enable, rest zero
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [71:0]                  s_axis_tdata,
    // m_axis_tdata: [31:0] filtered_diff, [32] turning, rest zero
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [39:0]                  m_axis_tdata,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [adtd_pkg::CFG_AW-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import adtd_pkg::*;

    logic signed [31:0] r_dc_offset;
    logic        [30:0] r_threshold;
    t_coefs             r_coefs;

    logic               r_out_valid;
    logic signed [31:0] r_out_diff;
    logic               r_out_turn;

    t_issue             w_issue;
    logic               w_in_ready;
    logic               w_out_full;
    logic               w_lp;
    logic signed [31:0] w_y;
    logic               w_turning;
    logic               w_win_wr;
    logic               w_cfg_wr;
    t_reg_idx           w_idx;

    assign pready   = 1'b1;
    assign w_idx    = t_reg_idx'(paddr[4:2]);
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (w_idx)
            REG_DC_OFFSET: prdata = r_dc_offset;
            REG_THRESHOLD: prdata = {1'b0, r_threshold};
            REG_COEF_B0:   prdata = r_coefs.b0;
            REG_COEF_B1:   prdata = r_coefs.b1;
            REG_COEF_B2:   prdata = r_coefs.b2;
            REG_COEF_A1:   prdata = r_coefs.a1;
            REG_COEF_A2:   prdata = r_coefs.a2;
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dc_offset <= DC_OFFSET_RST;
            r_threshold <= THRESHOLD_RST;
            r_coefs.b0  <= COEF_B0_RST;
            r_coefs.b1  <= COEF_B1_RST;
            r_coefs.b2  <= COEF_B2_RST;
            r_coefs.a1  <= COEF_A1_RST;
            r_coefs.a2  <= COEF_A2_RST;
        end else if (w_cfg_wr) begin
            unique case (w_idx)
                REG_DC_OFFSET: r_dc_offset <= pwdata;
                REG_THRESHOLD: r_threshold <= pwdata[30:0];
                REG_COEF_B0:   r_coefs.b0  <= pwdata;
                REG_COEF_B1:   r_coefs.b1  <= pwdata;
                REG_COEF_B2:   r_coefs.b2  <= pwdata;
                REG_COEF_A1:   r_coefs.a1  <= pwdata;
                REG_COEF_A2:   r_coefs.a2  <= pwdata;
                default: ;
            endcase
        end
    end

    assign w_out_full    = r_out_valid && !m_axis_tready;
    assign s_axis_tready = w_in_ready;

    adtd_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_out_full (w_out_full),
        .i_lp       (w_lp),
        .o_in_ready (w_in_ready),
        .o_issue    (w_issue)
    );

    adtd_datapath u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_issue          (w_issue),
        .i_accel_a_y      (s_axis_tdata[31:0]),
        .i_accel_b_y      (s_axis_tdata[63:32]),
        .i_lowpass_enable (s_axis_tdata[64]),
        .i_dc_offset      (r_dc_offset),
        .i_coefs          (r_coefs),
        .o_y              (w_y),
        .o_lp             (w_lp)
    );

    assign w_win_wr = w_issue.fire && (w_issue.ctrl.dst == DST_WIN);

    adtd_window #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_win (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_win_wr),
        .i_y         (w_y),
        .i_threshold (r_threshold),
        .o_turning   (w_turning)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_win_wr) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_win_wr) begin
            r_out_diff <= w_y;
            r_out_turn <= w_turning;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {7'd0, r_out_turn, r_out_diff};

endmodule

`default_nettype wire
